[rtl/core/rsd_pkg.sv]
// Shared types and constants for the run-length coded 32bpp sprite decoder.
// Holds the parse phase type, error codes and register map; no dependencies.

package rsd_pkg;

	// Widths fixed by the register and field definitions.
	localparam int unsigned DIM_W      = 12;
	localparam int unsigned LEN_W      = 23;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DATA_LENGTH  = 2'd2;

	// Sticky error codes reported with every result.
	localparam logic [2:0] ERR_NONE          = 3'd0;
	localparam logic [2:0] ERR_BEYOND_DATA   = 3'd1;
	localparam logic [2:0] ERR_WIDTH_OVERRUN = 3'd2;
	localparam logic [2:0] ERR_INCOMPLETE    = 3'd3;
	localparam logic [2:0] ERR_TRAILING_LINE = 3'd4;
	localparam logic [2:0] ERR_LINE_COUNT    = 3'd5;
	localparam logic [2:0] ERR_TRAILING_DATA = 3'd6;

	// Run kinds held in the top two bits of a mode byte.
	localparam logic [1:0] KIND_OPAQUE      = 2'd0;
	localparam logic [1:0] KIND_SEMI        = 2'd1;
	localparam logic [1:0] KIND_TRANSPARENT = 2'd2;
	localparam logic [1:0] KIND_RECOLOUR    = 2'd3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [3:0] {
		PH_LEN_LO = 4'd0,
		PH_LEN_HI = 4'd1,
		PH_MODE   = 4'd2,
		PH_ALPHA  = 4'd3,
		PH_LAYER  = 4'd4,
		PH_RALPHA = 4'd5,
		PH_RED    = 4'd6,
		PH_GREEN  = 4'd7,
		PH_BLUE   = 4'd8,
		PH_SHADE  = 4'd9
	} phase_t;

endpackage

[rtl/core/rsd_byte_if.sv]
// Channel carrying one coded data byte per beat into the sprite decoder.
// Plain valid/ready handshake; no package dependencies.

interface rsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_image;

	modport source (output valid, output data_byte, output start_of_image, input ready);
	modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

[rtl/core/rsd_pix_if.sv]
// Channel carrying one decoded pixel or transparent run per beat.
// Plain valid/ready handshake; no package dependencies.

interface rsd_pix_if;
	logic        valid;
	logic        ready;
	logic [10:0] line_index;
	logic [11:0] x_start;
	logic [11:0] run_length;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  layer;
	logic [7:0]  shade;
	logic [2:0]  error_code;
	logic        line_done;
	logic        image_done;

	modport source (
		output valid, output line_index, output x_start, output run_length,
		output red, output green, output blue, output alpha, output layer,
		output shade, output error_code, output line_done, output image_done,
		input ready
	);
	modport sink (
		input valid, input line_index, input x_start, input run_length,
		input red, input green, input blue, input alpha, input layer,
		input shade, input error_code, input line_done, input image_done,
		output ready
	);
endinterface

[rtl/core/rle_sprite_32bpp_decoder.sv]
// Top level of the run-length coded 32bpp sprite pixel decoder.
// Uses rsd_pkg, rsd_byte_if and rsd_pix_if.

// The decoder takes one coded byte per beat and sustains one byte per clock cycle: each byte
// is held in an input register, where a single pass of counter and field updates advances
// the line parser and fills the result register, from which a result beat is offered once
// the byte leaves the input register. The input is stalled only while the result
// register is full and its beat is not taken. Configuration must be written while no byte is in
// flight; image_width and image_height above MAX_WIDTH and MAX_HEIGHT are treated as those
// limits. Errors are sticky until a byte arrives with start_of_image set.
module rle_sprite_32bpp_decoder
	import rsd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	rsd_byte_if.sink              coded,
	rsd_pix_if.source             pixels
);

	// The register fields are 12 bits wide, so a limit beyond that range never bites.
	localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
	localparam logic [DIM_W-1:0] WIDTH_CAP  = DIM_W'((MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_CAP =
		DIM_W'((MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT);

	// Configuration registers.
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [LEN_W-1:0] data_length_q;
	logic             cfg_write;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       fire;

	// Parser state.
	phase_t           phase_q;
	logic [15:0]      lbl_q;
	logic             lte_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] ls_q;
	logic [5:0]       rpl_q;
	logic [1:0]       rk_q;
	logic [7:0]       pr_q;
	logic [7:0]       pg_q;
	logic [7:0]       ra_q;
	logic [7:0]       rly_q;
	logic [LEN_W-1:0] bc_q;
	logic [2:0]       se_q;

	// State as seen by the byte in the input register (cleared on start of image).
	phase_t           phase_v;
	logic [15:0]      lbl_v;
	logic             lte_v;
	logic [DIM_W-1:0] col_v;
	logic [DIM_W-1:0] ls_v;
	logic [5:0]       rpl_v;
	logic [1:0]       rk_v;
	logic [7:0]       pr_v;
	logic [7:0]       pg_v;
	logic [7:0]       ra_v;
	logic [7:0]       rly_v;
	logic [LEN_W-1:0] bc_v;
	logic [2:0]       se_v;

	// Next state.
	phase_t           phase_n;
	logic [15:0]      lbl_n;
	logic             lte_n;
	logic [DIM_W-1:0] col_n;
	logic [DIM_W-1:0] ls_n;
	logic [5:0]       rpl_n;
	logic [1:0]       rk_n;
	logic [7:0]       pr_n;
	logic [7:0]       pg_n;
	logic [7:0]       ra_n;
	logic [7:0]       rly_n;
	logic [LEN_W-1:0] bc_n;
	logic [2:0]       se_n;

	// Result fields worked out for the byte in the input register.
	logic             emit_c;
	logic [DIM_W-1:0] xs_c;
	logic [DIM_W-1:0] rl_c;
	logic [7:0]       red_c;
	logic [7:0]       green_c;
	logic [7:0]       blue_c;
	logic [7:0]       alpha_c;
	logic [7:0]       layer_c;
	logic [7:0]       shade_c;
	logic             ld_c;
	logic             done_c;
	logic [10:0]      li_c;

	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;
	logic [15:0]      len_c;
	logic [5:0]       count_c;
	logic [1:0]       kind_c;

	// Result register.
	logic             valid_s2;
	logic [10:0]      li_s2;
	logic [DIM_W-1:0] xs_s2;
	logic [DIM_W-1:0] rl_s2;
	logic [7:0]       red_s2;
	logic [7:0]       green_s2;
	logic [7:0]       blue_s2;
	logic [7:0]       alpha_s2;
	logic [7:0]       layer_s2;
	logic [7:0]       shade_s2;
	logic [2:0]       err_s2;
	logic             ld_s2;
	logic             done_s2;

	// ---------------------------------------------------------------- configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
			data_length_q  <= '0;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[DIM_W-1:0];
				REG_DATA_LENGTH:  data_length_q  <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_q);
			REG_DATA_LENGTH:  prdata = APB_DATA_W'(data_length_q);
			default:          prdata = '0;
		endcase
	end

	assign width_eff  = (image_width_q  > WIDTH_CAP)  ? WIDTH_CAP  : image_width_q;
	assign height_eff = (image_height_q > HEIGHT_CAP) ? HEIGHT_CAP : image_height_q;

	// ---------------------------------------------------------------- handshake
	assign fire        = valid_s1 && (!valid_s2 || pixels.ready);
	assign coded.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (coded.valid && coded.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (coded.valid && coded.ready) begin
			byte_s1  <= coded.data_byte;
			start_s1 <= coded.start_of_image;
		end
	end

	// ---------------------------------------------------------------- parser
	always_comb begin
		if (start_s1) begin
			phase_v = PH_LEN_LO;
			lbl_v   = '0;
			lte_v   = 1'b0;
			col_v   = '0;
			ls_v    = '0;
			rpl_v   = '0;
			rk_v    = '0;
			pr_v    = '0;
			pg_v    = '0;
			ra_v    = '0;
			rly_v   = '0;
			bc_v    = '0;
			se_v    = ERR_NONE;
		end else begin
			phase_v = phase_q;
			lbl_v   = lbl_q;
			lte_v   = lte_q;
			col_v   = col_q;
			ls_v    = ls_q;
			rpl_v   = rpl_q;
			rk_v    = rk_q;
			pr_v    = pr_q;
			pg_v    = pg_q;
			ra_v    = ra_q;
			rly_v   = rly_q;
			bc_v    = bc_q;
			se_v    = se_q;
		end
	end

	assign len_c   = {byte_s1, lbl_v[7:0]};
	assign count_c = byte_s1[5:0];
	assign kind_c  = byte_s1[7:6];

	always_comb begin
		phase_n = phase_v;
		lbl_n   = lbl_v;
		lte_n   = lte_v;
		col_n   = col_v;
		ls_n    = ls_v;
		rpl_n   = rpl_v;
		rk_n    = rk_v;
		pr_n    = pr_v;
		pg_n    = pg_v;
		ra_n    = ra_v;
		rly_n   = rly_v;
		bc_n    = bc_v;
		se_n    = se_v;
		emit_c  = 1'b0;
		xs_c    = col_v;
		rl_c    = '0;
		red_c   = '0;
		green_c = '0;
		blue_c  = '0;
		alpha_c = '0;
		layer_c = '0;
		shade_c = '0;
		ld_c    = 1'b0;

		if (bc_v >= data_length_q) begin
			if (se_v == ERR_NONE) begin
				se_n = ERR_TRAILING_DATA;
			end
		end else begin
			bc_n = bc_v + 1'b1;
			if (se_v == ERR_NONE) begin
				priority if (phase_v == PH_LEN_LO) begin
					if (ls_v != DIM_W'(DIM_MAX)) begin
						ls_n = ls_v + 1'b1;
					end
					lbl_n   = {8'd0, byte_s1};
					col_n   = '0;
					xs_c    = '0;
					rpl_n   = '0;
					phase_n = PH_LEN_HI;
				end else if (phase_v == PH_LEN_HI) begin
					phase_n = PH_MODE;
					lbl_n   = '0;
					if (len_c == 16'd0) begin
						lte_n = 1'b1;
					end else begin
						lte_n = 1'b0;
						// Lengths of one or two leave no budget and end up as incomplete.
						if (len_c >= 16'd2) begin
							if (LEN_W'(len_c - 16'd2) > (data_length_q - bc_n)) begin
								se_n = ERR_BEYOND_DATA;
							end else begin
								lbl_n = len_c - 16'd2;
							end
						end
					end
				end else begin
					if (!lte_v && (lbl_v != 16'd0)) begin
						lbl_n = lbl_v - 16'd1;
					end
					unique case (phase_v)
						PH_MODE: begin
							if (byte_s1 == 8'd0) begin
								if (width_eff > col_v) begin
									rl_c  = width_eff - col_v;
									col_n = width_eff;
								end
								emit_c  = 1'b1;
								ld_c    = 1'b1;
								phase_n = PH_LEN_LO;
								if (lte_v ? (bc_n < data_length_q) : (lbl_n != 16'd0)) begin
									se_n = ERR_TRAILING_LINE;
								end
							end else if (({1'b0, col_v} + (DIM_W+1)'(count_c)) >
									{1'b0, width_eff}) begin
								se_n = ERR_WIDTH_OVERRUN;
							end else begin
								rk_n  = kind_c;
								rpl_n = count_c;
								unique case (kind_c)
									KIND_OPAQUE: phase_n = (count_c != 6'd0) ? PH_RED : PH_MODE;
									KIND_SEMI:   phase_n = PH_ALPHA;
									KIND_RECOLOUR: phase_n = PH_LAYER;
									KIND_TRANSPARENT: begin
										if (count_c != 6'd0) begin
											rl_c   = DIM_W'(count_c);
											col_n  = col_v + DIM_W'(count_c);
											emit_c = 1'b1;
										end
									end
									default: ;
								endcase
							end
						end
						PH_ALPHA: begin
							ra_n    = byte_s1;
							phase_n = (rpl_v != 6'd0) ? PH_RED : PH_MODE;
						end
						PH_LAYER: begin
							rly_n   = byte_s1;
							phase_n = PH_RALPHA;
						end
						PH_RALPHA: begin
							ra_n    = byte_s1;
							phase_n = (rpl_v != 6'd0) ? PH_SHADE : PH_MODE;
						end
						PH_RED: begin
							pr_n    = byte_s1;
							phase_n = PH_GREEN;
						end
						PH_GREEN: begin
							pg_n    = byte_s1;
							phase_n = PH_BLUE;
						end
						PH_BLUE, PH_SHADE: begin
							if (phase_v == PH_BLUE) begin
								red_c   = pr_v;
								green_c = pg_v;
								blue_c  = byte_s1;
								alpha_c = (rk_v == KIND_OPAQUE) ? ALPHA_OPAQUE : ra_v;
							end else begin
								alpha_c = ra_v;
								layer_c = rly_v;
								shade_c = byte_s1;
							end
							rl_c   = DIM_W'(1);
							emit_c = 1'b1;
							col_n  = col_v + 1'b1;
							if (rpl_v != 6'd0) begin
								rpl_n = rpl_v - 6'd1;
							end
							if (rpl_n == 6'd0) begin
								phase_n = PH_MODE;
							end else begin
								phase_n = (phase_v == PH_BLUE) ? PH_RED : PH_SHADE;
							end
						end
						default: phase_n = PH_MODE;
					endcase
				end

				// The line budget running dry before its closing mode byte is caught at once.
				if ((se_n == ERR_NONE) && (phase_n != PH_LEN_LO) && (phase_n != PH_LEN_HI)) begin
					if (lte_n ? (bc_n >= data_length_q) : (lbl_n == 16'd0)) begin
						se_n = ERR_INCOMPLETE;
					end
				end
				if ((se_n == ERR_NONE) && (bc_n >= data_length_q)) begin
					priority if (phase_n == PH_LEN_HI) begin
						se_n = ERR_BEYOND_DATA;
					end else if (phase_n != PH_LEN_LO) begin
						se_n = ERR_INCOMPLETE;
					end else if (ls_n != height_eff) begin
						se_n = ERR_LINE_COUNT;
					end
				end
			end
		end
	end

	assign done_c = bc_n >= data_length_q;
	assign li_c   = (ls_n != '0) ? 11'(ls_n - 1'b1) : 11'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN_LO;
			lbl_q   <= '0;
			lte_q   <= 1'b0;
			col_q   <= '0;
			ls_q    <= '0;
			rpl_q   <= '0;
			rk_q    <= '0;
			pr_q    <= '0;
			pg_q    <= '0;
			ra_q    <= '0;
			rly_q   <= '0;
			bc_q    <= '0;
			se_q    <= ERR_NONE;
		end else if (fire) begin
			phase_q <= phase_n;
			lbl_q   <= lbl_n;
			lte_q   <= lte_n;
			col_q   <= col_n;
			ls_q    <= ls_n;
			rpl_q   <= rpl_n;
			rk_q    <= rk_n;
			pr_q    <= pr_n;
			pg_q    <= pg_n;
			ra_q    <= ra_n;
			rly_q   <= rly_n;
			bc_q    <= bc_n;
			se_q    <= se_n;
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= emit_c || (se_n != ERR_NONE) || done_c;
		end else if (pixels.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			li_s2    <= li_c;
			xs_s2    <= xs_c;
			rl_s2    <= rl_c;
			red_s2   <= red_c;
			green_s2 <= green_c;
			blue_s2  <= blue_c;
			alpha_s2 <= alpha_c;
			layer_s2 <= layer_c;
			shade_s2 <= shade_c;
			err_s2   <= se_n;
			ld_s2    <= ld_c;
			done_s2  <= done_c;
		end
	end

	assign pixels.valid      = valid_s2;
	assign pixels.line_index = li_s2;
	assign pixels.x_start    = xs_s2;
	assign pixels.run_length = rl_s2;
	assign pixels.red        = red_s2;
	assign pixels.green      = green_s2;
	assign pixels.blue       = blue_s2;
	assign pixels.alpha      = alpha_s2;
	assign pixels.layer      = layer_s2;
	assign pixels.shade      = shade_s2;
	assign pixels.error_code = err_s2;
	assign pixels.line_done  = ld_s2;
	assign pixels.image_done = done_s2;

	// ---------------------------------------------------------------- assertions
	// Once an error is latched only a new image may clear or change it.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !start_s1 && (se_q != ERR_NONE) |=> se_q == $past(se_q))
		else $error("sticky error changed without a start of image");

	// A beat that ends a line leaves the parser waiting for the next line length.
	a_line_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ld_c |=> phase_q == PH_LEN_LO)
		else $error("line end did not return the parser to the line length");

	// A held result must freeze the parser so that no byte is consumed unseen.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !pixels.ready |=> $stable(bc_q) && $stable(phase_q))
		else $error("parser advanced while the result register was stalled");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the run-length coded 32bpp sprite decoder: predicts every result
// beat from the coded bytes it feeds in and compares them as they leave.
// Uses rsd_pkg and both channel interfaces.

module testbench;
	import rsd_pkg::*;

	localparam int unsigned MAX_W = 2048;
	localparam int unsigned MAX_H = 2048;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned TOTAL_ITEMS  = 1350;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [10:0] line_index;
		logic [11:0] x_start;
		logic [11:0] run_length;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  layer;
		logic [7:0]  shade;
		logic [2:0]  error_code;
		logic        line_done;
		logic        image_done;
	} pix_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rsd_byte_if coded();
	rsd_pix_if  pixels();

	rle_sprite_32bpp_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coded   (coded),
		.pixels  (pixels)
	);

	// Decoder copy used for prediction.
	logic [11:0] cfg_width;
	logic [11:0] cfg_height;
	logic [22:0] cfg_length;
	phase_t      parse_phase;
	logic [16:0] line_budget;
	logic        line_runs_to_end;
	logic [11:0] cur_column;
	logic [11:0] lines_counted;
	logic [5:0]  run_left;
	logic [1:0]  cur_kind;
	logic [1:0]  pixel_byte;
	logic [7:0]  red_hold;
	logic [7:0]  green_hold;
	logic [7:0]  run_alpha_hold;
	logic [7:0]  run_layer_hold;
	logic [22:0] bytes_taken;
	logic        line_closed;
	logic [2:0]  sticky_err;

	pix_beat_t   expected_beats[$];
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	int unsigned hold_left  = 0;
	int unsigned sink_gap   = 0;
	bit          src_idling  = 1'b0;
	bit          sink_idling = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	function automatic string beat_text(input pix_beat_t p);
		return $sformatf({"line=%0d x=%0d run=%0d rgba=%02x%02x%02x%02x layer=%02x shade=%02x",
			" err=%0d ld=%0b id=%0b"},
			p.line_index, p.x_start, p.run_length, p.red, p.green, p.blue, p.alpha,
			p.layer, p.shade, p.error_code, p.line_done, p.image_done);
	endfunction

	task automatic clear_parse_state();
		parse_phase      = PH_LEN_LO;
		line_budget      = '0;
		line_runs_to_end = 1'b0;
		cur_column       = '0;
		lines_counted    = '0;
		run_left         = '0;
		cur_kind         = '0;
		pixel_byte       = '0;
		red_hold         = '0;
		green_hold       = '0;
		run_alpha_hold   = '0;
		run_layer_hold   = '0;
		bytes_taken      = '0;
		line_closed      = 1'b0;
		sticky_err       = ERR_NONE;
	endtask

	// Works out what one accepted coded byte produces and queues the result beat, if any.
	task automatic predict_beat(input logic [7:0] b, input logic soi);
		int unsigned w, h, n, len, room;
		logic [1:0]  kind;
		logic [11:0] line_no;
		logic        emit, done;
		pix_beat_t   e;
		w = (cfg_width > MAX_W) ? MAX_W : cfg_width;
		h = (cfg_height > MAX_H) ? MAX_H : cfg_height;
		e = '0;
		emit = 1'b0;
		if (soi) begin
			clear_parse_state();
		end
		e.x_start = cur_column;
		if (bytes_taken >= cfg_length) begin
			if (sticky_err == ERR_NONE) begin
				sticky_err = ERR_TRAILING_DATA;
			end
		end else begin
			bytes_taken = bytes_taken + 1'b1;
			if (sticky_err == ERR_NONE) begin
				if (parse_phase == PH_LEN_LO) begin
					if (lines_counted < 12'd4095) begin
						lines_counted = lines_counted + 1'b1;
					end
					line_budget = 17'(b);
					line_closed = 1'b0;
					cur_column = '0;
					e.x_start = '0;
					run_left = '0;
					pixel_byte = '0;
					parse_phase = PH_LEN_HI;
				end else if (parse_phase == PH_LEN_HI) begin
					len = {b, line_budget[7:0]};
					parse_phase = PH_MODE;
					line_budget = '0;
					if (len == 0) begin
						line_runs_to_end = 1'b1;
					end else begin
						line_runs_to_end = 1'b0;
						if (len >= 2) begin
							room = cfg_length - bytes_taken;
							if (len - 2 > room) begin
								sticky_err = ERR_BEYOND_DATA;
							end else begin
								line_budget = 17'(len - 2);
							end
						end
					end
				end else begin
					if (!line_runs_to_end && line_budget > 0) begin
						line_budget = line_budget - 1'b1;
					end
					case (parse_phase)
					PH_MODE: begin
						n = b[5:0];
						kind = b[7:6];
						if (b == 8'h00) begin
							// Fill to the end of the line; the run may be empty.
							e.run_length = (w > cur_column) ? 12'(w - cur_column) : 12'd0;
							if (w > cur_column) begin
								cur_column = 12'(w);
							end
							emit = 1'b1;
							e.line_done = 1'b1;
							line_closed = 1'b1;
							parse_phase = PH_LEN_LO;
							if (line_runs_to_end ? (bytes_taken < cfg_length)
									: (line_budget > 0)) begin
								sticky_err = ERR_TRAILING_LINE;
							end
						end else if (cur_column + n > w) begin
							sticky_err = ERR_WIDTH_OVERRUN;
						end else begin
							cur_kind = kind;
							run_left = 6'(n);
							pixel_byte = '0;
							case (kind)
							KIND_OPAQUE: begin
								if (n != 0) parse_phase = PH_RED;
								else parse_phase = PH_MODE;
							end
							KIND_SEMI:     parse_phase = PH_ALPHA;
							KIND_RECOLOUR: parse_phase = PH_LAYER;
							default: begin
								if (n != 0) begin
									e.run_length = 12'(n);
									cur_column = 12'(cur_column + n);
									emit = 1'b1;
								end
							end
							endcase
						end
					end
					PH_ALPHA: begin
						run_alpha_hold = b;
						if (run_left != 0) parse_phase = PH_RED;
						else parse_phase = PH_MODE;
					end
					PH_LAYER: begin
						run_layer_hold = b;
						parse_phase = PH_RALPHA;
					end
					PH_RALPHA: begin
						run_alpha_hold = b;
						if (run_left != 0) parse_phase = PH_SHADE;
						else parse_phase = PH_MODE;
					end
					PH_RED: begin
						red_hold = b;
						pixel_byte = 2'd1;
						parse_phase = PH_GREEN;
					end
					PH_GREEN: begin
						green_hold = b;
						pixel_byte = 2'd2;
						parse_phase = PH_BLUE;
					end
					PH_BLUE, PH_SHADE: begin
						if (parse_phase == PH_BLUE) begin
							e.red = red_hold;
							e.green = green_hold;
							e.blue = b;
							e.alpha = (cur_kind == KIND_OPAQUE) ? ALPHA_OPAQUE : run_alpha_hold;
						end else begin
							e.alpha = run_alpha_hold;
							e.layer = run_layer_hold;
							e.shade = b;
						end
						e.run_length = 12'd1;
						emit = 1'b1;
						cur_column = cur_column + 1'b1;
						pixel_byte = '0;
						if (run_left > 0) begin
							run_left = run_left - 1'b1;
						end
						if (run_left == 0) parse_phase = PH_MODE;
						else if (parse_phase == PH_BLUE) parse_phase = PH_RED;
						else parse_phase = PH_SHADE;
					end
					default: parse_phase = PH_MODE;
					endcase
				end
				if (sticky_err == ERR_NONE && parse_phase >= PH_MODE) begin
					if (line_runs_to_end ? (bytes_taken >= cfg_length)
							: (line_budget == 0)) begin
						sticky_err = ERR_INCOMPLETE;
					end
				end
				if (sticky_err == ERR_NONE && bytes_taken >= cfg_length) begin
					if (parse_phase == PH_LEN_HI) sticky_err = ERR_BEYOND_DATA;
					else if (parse_phase != PH_LEN_LO) sticky_err = ERR_INCOMPLETE;
					else if (lines_counted != h) sticky_err = ERR_LINE_COUNT;
				end
			end
		end
		done = (bytes_taken >= cfg_length);
		if (sticky_err != ERR_NONE || done) begin
			emit = 1'b1;
		end
		if (emit) begin
			line_no = (lines_counted != 0) ? lines_counted - 1'b1 : 12'd0;
			e.line_index = line_no[10:0];
			e.error_code = sticky_err;
			e.image_done = done;
			expected_beats.push_back(e);
		end
	endtask

	// Result side: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		pixels.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pixels.ready <= 1'b0;
				hold_left--;
			end else if (sink_gap > 0) begin
				pixels.ready <= 1'b0;
				sink_gap--;
			end else if (sink_idling && $urandom_range(0, 5) == 0) begin
				pixels.ready <= 1'b0;
				sink_gap = $urandom_range(0, 15);
			end else begin
				pixels.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_beats
		pix_beat_t got;
		pix_beat_t want;
		if (arst_n && pixels.valid && pixels.ready) begin
			got = {pixels.line_index, pixels.x_start, pixels.run_length, pixels.red,
				pixels.green, pixels.blue, pixels.alpha, pixels.layer, pixels.shade,
				pixels.error_code, pixels.line_done, pixels.image_done};
			if (expected_beats.size() == 0) begin
				flag_error($sformatf("unexpected result beat: %s", beat_text(got)));
			end else begin
				want = expected_beats.pop_front();
				if (got !== want) begin
					flag_error($sformatf("result mismatch\n  expected %s\n  actual   %s",
						beat_text(want), beat_text(got)));
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic soi);
		if (src_idling && $urandom_range(0, 5) == 0) begin
			coded.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		coded.valid <= 1'b1;
		coded.data_byte <= value;
		coded.start_of_image <= soi;
		do begin
			@(posedge clk);
		end while (!coded.ready);
		predict_beat(value, soi);
		items_sent++;
	endtask

	task automatic stream_bytes(input byte_q_t img, input int lo_idx, input int hi_idx,
		input logic soi_first);
		for (int i = lo_idx; i <= hi_idx; i++) begin
			send_byte(img[i], soi_first && i == lo_idx);
		end
	endtask

	task automatic wait_drained();
		coded.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_beats.size() != 0);
	endtask

	// A byte may produce no beat, so allow the pipeline to empty after the last one.
	task automatic settle();
		wait_drained();
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_read_reg(input logic [1:0] idx, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] mask, stored, readback;
		mask = (idx == REG_DATA_LENGTH) ? 32'h007F_FFFF : 32'h0000_0FFF;
		stored = value & mask;
		// Unused upper bits are sometimes set to show they are dropped.
		if ($urandom_range(0, 1) == 1) begin
			value = stored | ($urandom & ~mask);
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		case (idx)
		REG_IMAGE_WIDTH:  cfg_width  = stored[11:0];
		REG_IMAGE_HEIGHT: cfg_height = stored[11:0];
		default:          cfg_length = stored[22:0];
		endcase
		apb_read_reg(idx, readback);
		if (readback !== stored) begin
			flag_error($sformatf("register %0d read back: expected %h actual %h",
				idx, stored, readback));
		end
	endtask

	task automatic configure_image(input int unsigned w, input int unsigned h,
		input int unsigned dl);
		settle();
		apb_write_reg(REG_IMAGE_WIDTH, w);
		apb_write_reg(REG_IMAGE_HEIGHT, h);
		apb_write_reg(REG_DATA_LENGTH, dl);
	endtask

	task automatic run_image(input int unsigned w, input int unsigned h, input int unsigned dl,
		input byte_q_t img);
		configure_image(w, h, dl);
		stream_bytes(img, 0, img.size() - 1, 1'b1);
	endtask

	// Builds well-formed coded lines of random runs; w must already be within MAX_W.
	task automatic build_sprite(input int unsigned w, input int unsigned nlines,
		output byte_q_t img);
		byte_q_t     body;
		int unsigned col, rem, lim, n, kind, len;
		bit          to_end;
		img = {};
		for (int ln = 0; ln < nlines; ln++) begin
			body = {};
			col = 0;
			while (col < w && body.size() < 60 && $urandom_range(0, 7) != 0) begin
				rem = w - col;
				lim = (rem < 63) ? rem : 63;
				kind = $urandom_range(0, 3);
				n = $urandom_range(0, lim);
				if (kind[1:0] == KIND_OPAQUE && n == 0) begin
					n = 1;
				end
				body.push_back({kind[1:0], n[5:0]});
				case (kind[1:0])
				KIND_OPAQUE: repeat (3 * n) body.push_back(8'($urandom_range(0, 255)));
				KIND_SEMI: begin
					body.push_back(8'($urandom_range(0, 255)));
					repeat (3 * n) body.push_back(8'($urandom_range(0, 255)));
				end
				KIND_RECOLOUR: begin
					body.push_back(8'($urandom_range(0, 255)));
					body.push_back(8'($urandom_range(0, 255)));
					repeat (n) body.push_back(8'($urandom_range(0, 255)));
				end
				default: ;
				endcase
				col += n;
			end
			body.push_back(8'h00);
			// Only the last line may run to the end of the data.
			to_end = (ln == nlines - 1) && $urandom_range(0, 4) == 0;
			len = to_end ? 0 : body.size() + 2;
			img.push_back(len[7:0]);
			img.push_back(len[15:8]);
			foreach (body[i]) img.push_back(body[i]);
		end
	endtask

	task automatic test_register_access();
		logic [31:0] value;
		apb_read_reg(REG_IMAGE_WIDTH, value);
		if (value !== 32'd1) flag_error($sformatf("image_width after reset: %h", value));
		apb_read_reg(REG_IMAGE_HEIGHT, value);
		if (value !== 32'd1) flag_error($sformatf("image_height after reset: %h", value));
		apb_read_reg(REG_DATA_LENGTH, value);
		if (value !== 32'd0) flag_error($sformatf("data_length after reset: %h", value));
		apb_write_reg(REG_IMAGE_WIDTH, 32'd0);
		apb_write_reg(REG_IMAGE_WIDTH, 32'd4095);
		apb_write_reg(REG_IMAGE_HEIGHT, 32'd0);
		apb_write_reg(REG_IMAGE_HEIGHT, 32'd4095);
		apb_write_reg(REG_DATA_LENGTH, 32'h007F_FFFF);
		apb_write_reg(REG_DATA_LENGTH, 32'd4194304);
		apb_write_reg(REG_DATA_LENGTH, 32'd0);
	endtask

	task automatic test_directed_cases();
		byte_q_t img;
		src_idling = 1'b1;
		sink_idling = 1'b1;
		// Every run kind once, empty runs of the semi, transparent and recolour kinds, then fill.
		img = '{8'd23, 8'h00,
			8'h01, 8'hFF, 8'h00, 8'h80,
			8'h41, 8'h7F, 8'h01, 8'hFE, 8'h55,
			8'h82,
			8'hC1, 8'hFF, 8'h00, 8'hAA,
			8'h40, 8'h33,
			8'h80,
			8'hC0, 8'h05, 8'h06,
			8'h00};
		run_image(8, 1, 23, img);
		// Width and height above the limits, a line to the end, and too few lines.
		img = '{8'h00, 8'h00, 8'hBF, 8'h00};
		run_image(4095, 4095, 4, img);
		// Line length of one.
		img = '{8'h01, 8'h00};
		run_image(4, 1, 2, img);
		// Line reaching past the data.
		img = '{8'h0A, 8'h00, 8'h33};
		run_image(4, 1, 4, img);
		// Data ending after a length low byte.
		img = '{8'h05};
		run_image(4, 1, 1, img);
		// No data at all: the byte is trailing.
		img = '{8'h00};
		run_image(4, 1, 0, img);
		// Run wider than the line.
		img = '{8'h05, 8'h00, 8'h02, 8'hFF, 8'h00};
		run_image(1, 1, 5, img);
		// Bytes left in the line after the fill.
		img = '{8'h05, 8'h00, 8'h00, 8'h11, 8'h22};
		run_image(4, 1, 5, img);
		// Line budget spent inside a run.
		img = '{8'h04, 8'h00, 8'h01, 8'hFF};
		run_image(4, 1, 6, img);
	endtask

	task automatic test_back_pressure();
		byte_q_t img;
		img = {};
		repeat (40) img.push_back(8'($urandom_range(0, 255)));
		src_idling = 1'b0;
		sink_idling = 1'b0;
		// With no data every byte gives a beat, so the held output fills and the input stalls.
		configure_image(8, 1, 0);
		hold_left = 300;
		stream_bytes(img, 0, img.size() - 1, 1'b1);
	endtask

	task automatic test_sender_pause();
		byte_q_t img;
		int      mid;
		build_sprite(12, 3, img);
		src_idling = 1'b1;
		sink_idling = 1'b1;
		configure_image(12, 3, img.size());
		mid = img.size() / 2;
		stream_bytes(img, 0, mid - 1, 1'b1);
		wait_drained();
		stream_bytes(img, mid, img.size() - 1, 1'b0);
	endtask

	task automatic test_restart();
		byte_q_t img;
		repeat (3) begin
			build_sprite($urandom_range(1, 16), $urandom_range(1, 3), img);
			configure_image(16, 3, img.size());
			// Abandon part way through, then start the same sprite again.
			stream_bytes(img, 0, $urandom_range(0, img.size() - 2), 1'b1);
			stream_bytes(img, 0, img.size() - 1, 1'b1);
		end
	endtask

	task automatic random_image(input bit clean_only);
		int unsigned w, h, nlines, variant, dl;
		byte_q_t     img;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
			0: w = 0;
			1: w = MAX_W;
			2: w = 4095;
			default: w = $urandom_range(MAX_W + 1, 4095);
			endcase
		end else begin
			w = $urandom_range(1, 24);
		end
		if ($urandom_range(0, 9) == 0) begin
			h = $urandom_range(0, 1) ? 0 : 4095;
			nlines = $urandom_range(1, 3);
		end else begin
			h = $urandom_range(1, 4);
			nlines = h;
		end
		build_sprite((w > MAX_W) ? MAX_W : w, nlines, img);
		dl = img.size();
		variant = clean_only ? 0 : $urandom_range(0, 11);
		case (variant)
		6: repeat ($urandom_range(1, 6)) img.push_back(8'($urandom_range(0, 255)));
		7: dl = $urandom_range(0, img.size() - 1);
		8: h = (h != 0 && $urandom_range(0, 1) == 1) ? h - 1 : h + 1;
		9: img[$urandom_range(0, img.size() - 1)] = 8'($urandom_range(0, 255));
		10: begin
			img = {};
			repeat ($urandom_range(1, 40)) img.push_back(8'($urandom_range(0, 255)));
			dl = $urandom_range(0, 48);
		end
		11: dl = ($urandom_range(0, 3) == 0) ? 32'h007F_FFFF : dl + $urandom_range(1, 20);
		default: ;
		endcase
		run_image(w, h, dl, img);
	endtask

	task automatic test_random_sprites();
		while (items_sent < RANDOM_ITEMS) begin
			src_idling = ($urandom_range(0, 3) != 0);
			sink_idling = ($urandom_range(0, 3) != 0);
			random_image(1'b0);
		end
	endtask

	task automatic test_steady_stream();
		src_idling = 1'b0;
		sink_idling = 1'b0;
		while (items_sent < TOTAL_ITEMS) begin
			random_image(1'b1);
		end
	endtask

	initial begin : main
		int unsigned waited;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		coded.valid <= 1'b0;
		coded.data_byte <= '0;
		coded.start_of_image <= 1'b0;
		cfg_width = 12'd1;
		cfg_height = 12'd1;
		cfg_length = '0;
		clear_parse_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_cases();
		test_back_pressure();
		test_sender_pause();
		test_restart();
		test_random_sprites();
		test_steady_stream();

		coded.valid <= 1'b0;
		waited = 0;
		while (expected_beats.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_beats.size() != 0) begin
			flag_error($sformatf("%0d expected result beats never arrived, oldest %s",
				expected_beats.size(), beat_text(expected_beats[0])));
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/rsd_pkg.sv
rtl/core/rsd_byte_if.sv
rtl/core/rsd_pix_if.sv
rtl/core/rle_sprite_32bpp_decoder.sv
dv/testbench.sv
